// File: rtl/core/mhpq_pkg.sv
package mhpq_pkg;

  localparam int unsigned CAPACITY_DEF    = 1024;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // Fixed field widths of the stream payloads
  localparam int unsigned VALUE_FIELD_W = 32;
  localparam int unsigned COUNT_FIELD_W = 11;
  localparam int unsigned OUT_TDATA_W   = 48;
  localparam int unsigned OUT_TUSER_W   = 2;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  // Control part of the token that walks down the row of level cells
  typedef struct packed {
    logic valid;
    op_t  op;
  } tok_ctl_t;

  // Per-cell status seen by the sequencer
  typedef struct packed {
    logic fin;
    logic wr_seen;
  } cell_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_FETCH = 2'd1,
    ST_RUN   = 2'd2,
    ST_DONE  = 2'd3
  } state_t;

  // Number of heap nodes that live on one level, trimmed on the last level
  function automatic int unsigned level_depth(input int unsigned lvl, input int unsigned cap);
    int unsigned full_row;
    int unsigned rest;
    full_row = 32'd1 << lvl;
    rest     = cap + 1 - full_row;
    return (rest < full_row) ? rest : full_row;
  endfunction

endpackage

// File: rtl/core/mhpq_cell.sv
module mhpq_cell #(
  parameter int unsigned LEVEL       = 0,
  parameter int unsigned CAPACITY    = mhpq_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = mhpq_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  // token from the level above
  input  mhpq_pkg::tok_ctl_t                        in_ctl,
  input  logic signed [VALUE_WIDTH-1:0]             in_val,
  input  logic [$clog2(CAPACITY+1)-2:0]             in_pos,
  input  logic [$clog2(CAPACITY+1)-1:0]             in_aux,
  input  logic [$clog2($clog2(CAPACITY+1))-1:0]     in_lvl,
  // token to the level below
  output mhpq_pkg::tok_ctl_t                        out_ctl,
  output logic signed [VALUE_WIDTH-1:0]             out_val,
  output logic [$clog2(CAPACITY+1)-2:0]             out_pos,
  output logic [$clog2(CAPACITY+1)-1:0]             out_aux,
  output logic [$clog2($clog2(CAPACITY+1))-1:0]     out_lvl,
  // write-back from the level below into this level
  input  logic                                      wb_in_en,
  input  logic [$clog2(CAPACITY+1)-2:0]             wb_in_pos,
  input  logic signed [VALUE_WIDTH-1:0]             wb_in_val,
  // write-back from this level into the level above
  output logic                                      wb_out_en,
  output logic [$clog2(CAPACITY+1)-2:0]             wb_out_pos,
  output logic signed [VALUE_WIDTH-1:0]             wb_out_val,
  // random read for the last-leaf fetch
  input  logic                                      fetch_en,
  input  logic [$clog2(CAPACITY+1)-2:0]             fetch_pos,
  output logic signed [VALUE_WIDTH-1:0]             rd_val,
  output mhpq_pkg::cell_stat_t                      stat,
  output logic signed [VALUE_WIDTH-1:0]             wr_val
);
  import mhpq_pkg::*;

  localparam int unsigned LEVELS = $clog2(CAPACITY + 1);
  localparam int unsigned PW     = LEVELS - 1;
  localparam int unsigned CW     = LEVELS;
  localparam int unsigned LW     = $clog2(LEVELS);
  localparam int unsigned GW     = CW + 1;
  localparam int unsigned DEPTH  = level_depth(LEVEL, CAPACITY);
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned BASE   = (32'd1 << LEVEL) - 1;

  logic signed [VALUE_WIDTH-1:0] mem [0:DEPTH-1];

  tok_ctl_t                      ctl_q;
  logic                          phase_q;
  logic signed [VALUE_WIDTH-1:0] val_q;
  logic [PW-1:0]                 pos_q;
  logic [CW-1:0]                 aux_q;
  logic [LW-1:0]                 lvl_q;

  logic signed [VALUE_WIDTH-1:0] rd_a;
  logic signed [VALUE_WIDTH-1:0] rd_b;
  logic [AW-1:0]                 addr_a;
  logic [AW-1:0]                 addr_b;

  logic                          we;
  logic [AW-1:0]                 wa;
  logic signed [VALUE_WIDTH-1:0] wd;
  logic                          m_we;
  logic [AW-1:0]                 m_wa;
  logic signed [VALUE_WIDTH-1:0] m_wd;
  logic                          fin;

  // token: phase 0 reads, phase 1 compares, writes and hands on
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q   <= '0;
      phase_q <= 1'b0;
    end else if (in_ctl.valid) begin
      ctl_q   <= in_ctl;
      phase_q <= 1'b0;
    end else if (ctl_q.valid && !phase_q) begin
      phase_q <= 1'b1;
    end else if (ctl_q.valid && phase_q) begin
      ctl_q.valid <= 1'b0;
      phase_q     <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ctl.valid) begin
      val_q <= in_val;
      pos_q <= in_pos;
      aux_q <= in_aux;
      lvl_q <= in_lvl;
    end
  end

  always_comb begin
    addr_a = AW'(pos_q);
    addr_b = AW'({pos_q, 1'b1});
    if (ctl_q.op == OP_POP) begin
      addr_a = AW'({pos_q, 1'b0});
    end
    if (fetch_en) begin
      addr_a = AW'(fetch_pos);
    end
  end

  always_comb begin
    logic [LW-1:0]                 bit_idx;
    logic [GW-1:0]                 g_l;
    logic [GW-1:0]                 g_r;
    logic [GW-1:0]                 n_ext;
    logic                          has_l;
    logic                          has_r;
    logic                          moved;
    logic                          sel;
    logic signed [VALUE_WIDTH-1:0] best;
    bit_idx    = lvl_q - LW'(LEVEL) - LW'(1);
    g_l        = GW'(BASE) + GW'({pos_q, 1'b0});
    g_r        = g_l + GW'(1);
    n_ext      = GW'(aux_q);
    has_l      = g_l < n_ext;
    has_r      = g_r < n_ext;
    moved      = 1'b0;
    sel        = 1'b0;
    best       = val_q;
    we         = 1'b0;
    wa         = AW'(pos_q);
    wd         = val_q;
    fin        = 1'b0;
    out_ctl    = '0;
    out_val    = val_q;
    out_pos    = pos_q;
    out_aux    = aux_q;
    out_lvl    = lvl_q;
    wb_out_en  = 1'b0;
    wb_out_pos = pos_q;
    wb_out_val = val_q;
    if (ctl_q.valid && phase_q) begin
      unique case (ctl_q.op)
        OP_PUSH: begin
          if (lvl_q == LW'(LEVEL)) begin
            // new leaf slot: drop the carried value here
            we  = 1'b1;
            fin = 1'b1;
          end else begin
            if (val_q > rd_a) begin
              we      = 1'b1;
              out_val = rd_a;
            end
            out_ctl       = ctl_q;
            out_ctl.valid = 1'b1;
            out_pos       = PW'({pos_q, aux_q[bit_idx]});
          end
        end
        OP_POP: begin
          if (has_l && (val_q < rd_a)) begin
            best  = rd_a;
            moved = 1'b1;
            sel   = 1'b0;
          end
          if (has_r && (best < rd_b)) begin
            best  = rd_b;
            moved = 1'b1;
            sel   = 1'b1;
          end
          if (moved) begin
            // swap: larger child goes up, sifted value lands in the child slot
            wb_out_en     = 1'b1;
            wb_out_val    = best;
            we            = 1'b1;
            wa            = AW'({pos_q, sel});
            out_ctl       = ctl_q;
            out_ctl.valid = 1'b1;
            out_pos       = PW'({pos_q, sel});
          end else begin
            fin = 1'b1;
          end
        end
        default: begin
          fin = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    if (wb_in_en) begin
      m_we = 1'b1;
      m_wa = AW'(wb_in_pos);
      m_wd = wb_in_val;
    end else begin
      m_we = we;
      m_wa = wa;
      m_wd = wd;
    end
  end

  always_ff @(posedge clk) begin
    if (m_we) begin
      mem[m_wa] <= m_wd;
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  assign rd_val       = rd_a;
  assign stat.fin     = fin;
  assign stat.wr_seen = m_we;
  assign wr_val       = m_wd;

endmodule

// File: rtl/core/max_heap_priority_queue_core.sv
// Max priority queue: an implicit binary heap held as a row of level cells.
// A push walks its token from the root down to the level of the new leaf;
// a pop fetches the last leaf, then sifts it down. A rejected item or a pop
// of the only entry goes straight to the result. A held result adds its wait.
// One item at a time: the next input is taken in the cycle after the result loads.
// Reset: synchronous, clears the count and all control; heap memory is not cleared.
module max_heap_priority_queue_core #(
  parameter int unsigned CAPACITY    = mhpq_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = mhpq_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // s_tdata: value [31:0]
  input  logic [mhpq_pkg::VALUE_FIELD_W-1:0]  s_tdata,
  // s_tuser: action [0] (0 push, 1 pop)
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // m_tdata: top_value [31:0], entry_count [42:32], zero fill [47:43]
  output logic [mhpq_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // m_tuser: is_empty [0], rejected [1]
  output logic [mhpq_pkg::OUT_TUSER_W-1:0]    m_tuser
);
  import mhpq_pkg::*;

  localparam int unsigned LEVELS = $clog2(CAPACITY + 1);
  localparam int unsigned PW     = LEVELS - 1;
  localparam int unsigned CW     = LEVELS;
  localparam int unsigned LW     = $clog2(LEVELS);
  localparam int unsigned VW     = VALUE_WIDTH;
  localparam int unsigned PAD_W  = OUT_TDATA_W - VALUE_FIELD_W - COUNT_FIELD_W;

  state_t                state;
  state_t                state_next;
  logic [CW-1:0]         count;
  logic signed [VW-1:0]  top_q;
  logic                  rej_q;
  logic [LW-1:0]         fetch_lvl_q;
  logic [CW-1:0]         pop_n_q;

  logic                  accept;
  logic                  is_pop;
  logic                  full;
  logic                  empty;
  logic signed [VW-1:0]  in_v;
  logic [CW-1:0]         push_path;
  logic [LW-1:0]         push_lvl;
  logic [LW-1:0]         pop_lvl;
  logic [PW-1:0]         pop_pos;

  logic                  push_go;
  logic                  fetch_go;
  logic                  pop_go;
  logic                  out_load;
  logic                  fin_any;
  logic signed [VW-1:0]  fetch_data;

  logic [VALUE_FIELD_W-1:0] top_field;
  logic [COUNT_FIELD_W-1:0] count_field;
  logic [VALUE_FIELD_W-1:0] top_out_q;
  logic [COUNT_FIELD_W-1:0] count_out_q;
  logic                     empty_out_q;
  logic                     rej_out_q;

  // cell row wiring
  tok_ctl_t              cin_ctl  [LEVELS];
  logic signed [VW-1:0]  cin_val  [LEVELS];
  logic [PW-1:0]         cin_pos  [LEVELS];
  logic [CW-1:0]         cin_aux  [LEVELS];
  logic [LW-1:0]         cin_lvl  [LEVELS];
  tok_ctl_t              cout_ctl [LEVELS];
  logic signed [VW-1:0]  cout_val [LEVELS];
  logic [PW-1:0]         cout_pos [LEVELS];
  logic [CW-1:0]         cout_aux [LEVELS];
  logic [LW-1:0]         cout_lvl [LEVELS];
  logic                  wbin_en  [LEVELS];
  logic [PW-1:0]         wbin_pos [LEVELS];
  logic signed [VW-1:0]  wbin_val [LEVELS];
  logic                  wbout_en [LEVELS];
  logic [PW-1:0]         wbout_pos[LEVELS];
  logic signed [VW-1:0]  wbout_val[LEVELS];
  logic                  fetch_en [LEVELS];
  logic signed [VW-1:0]  rd_val   [LEVELS];
  cell_stat_t            stat     [LEVELS];
  logic signed [VW-1:0]  wr_val   [LEVELS];

  // position of the highest set bit, i.e. the heap level of a 1-based index
  function automatic logic [LW-1:0] msb_pos(input logic [CW-1:0] x);
    logic [LW-1:0] r;
    r = '0;
    for (int i = 0; i < CW; i++) begin
      if (x[i]) begin
        r = LW'(i);
      end
    end
    return r;
  endfunction

  // Narrow the input value; wide stores take the 32-bit pattern unsigned.
  if (VW > VALUE_FIELD_W) begin : g_in_wide
    assign in_v = {{(VW - VALUE_FIELD_W){1'b0}}, s_tdata};
  end else begin : g_in_narrow
    assign in_v = s_tdata[VW-1:0];
  end

  // Sign-extend or cut the root back to the 32-bit field.
  if (VW >= VALUE_FIELD_W) begin : g_top_wide
    assign top_field = top_q[VALUE_FIELD_W-1:0];
  end else begin : g_top_narrow
    assign top_field = {{(VALUE_FIELD_W - VW){top_q[VW-1]}}, top_q};
  end

  if (CW >= COUNT_FIELD_W) begin : g_cnt_wide
    assign count_field = count[COUNT_FIELD_W-1:0];
  end else begin : g_cnt_narrow
    assign count_field = {{(COUNT_FIELD_W - CW){1'b0}}, count};
  end

  assign accept    = s_tvalid && s_tready;
  assign is_pop    = s_tuser;
  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);
  // new leaf sits at 1-based index count+1; its bits below the MSB give the path
  assign push_path = count + CW'(1);
  assign push_lvl  = msb_pos(push_path);
  // last leaf has 1-based index count
  assign pop_lvl   = msb_pos(count);
  assign pop_pos   = PW'(count & ~(CW'(1) << pop_lvl));
  assign fetch_data = rd_val[fetch_lvl_q];

  // next-state logic
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!is_pop) begin
            state_next = full ? ST_DONE : ST_RUN;
          end else if (empty || (count == CW'(1))) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_FETCH;
          end
        end
      end
      ST_FETCH: state_next = ST_RUN;
      ST_RUN: begin
        if (fin_any) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready = (state == ST_IDLE);
    push_go  = (state == ST_IDLE) && s_tvalid && !is_pop && !full;
    fetch_go = (state == ST_IDLE) && s_tvalid && is_pop && !empty && (count != CW'(1));
    pop_go   = (state == ST_FETCH);
    out_load = (state == ST_DONE) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (!is_pop && !full) begin
          count <= count + CW'(1);
        end else if (is_pop && !empty) begin
          count <= count - CW'(1);
        end
      end
    end
  end

  // hold per-item bookkeeping
  always_ff @(posedge clk) begin
    if (accept) begin
      rej_q       <= is_pop ? empty : full;
      fetch_lvl_q <= pop_lvl;
      pop_n_q     <= count - CW'(1);
    end
    // mirror every write into the root so the top value is always at hand
    if (stat[0].wr_seen) begin
      top_q <= wr_val[0];
    end
  end

  // token and write-back chain
  always_comb begin
    cin_ctl[0].valid = push_go;
    cin_ctl[0].op    = OP_PUSH;
    cin_val[0]       = in_v;
    cin_pos[0]       = '0;
    cin_aux[0]       = push_path;
    cin_lvl[0]       = push_lvl;
    for (int g = 1; g < LEVELS; g++) begin
      cin_ctl[g] = cout_ctl[g-1];
      cin_val[g] = cout_val[g-1];
      cin_pos[g] = cout_pos[g-1];
      cin_aux[g] = cout_aux[g-1];
      cin_lvl[g] = cout_lvl[g-1];
    end
    // pop: the last leaf sits in the root and starts its sift-down at level 1
    if (pop_go) begin
      cin_ctl[1].valid = 1'b1;
      cin_ctl[1].op    = OP_POP;
      cin_val[1]       = fetch_data;
      cin_pos[1]       = '0;
      cin_aux[1]       = pop_n_q;
      cin_lvl[1]       = '0;
    end
    for (int g = 0; g < LEVELS - 1; g++) begin
      wbin_en[g]  = wbout_en[g+1];
      wbin_pos[g] = wbout_pos[g+1];
      wbin_val[g] = wbout_val[g+1];
    end
    wbin_en[LEVELS-1]  = 1'b0;
    wbin_pos[LEVELS-1] = '0;
    wbin_val[LEVELS-1] = '0;
    if (pop_go) begin
      wbin_en[0]  = 1'b1;
      wbin_pos[0] = '0;
      wbin_val[0] = fetch_data;
    end
    for (int g = 0; g < LEVELS; g++) begin
      fetch_en[g] = fetch_go && (pop_lvl == LW'(g));
    end
    // a token leaving the bottom cell has nowhere left to go
    fin_any = cout_ctl[LEVELS-1].valid;
    for (int g = 0; g < LEVELS; g++) begin
      fin_any = fin_any | stat[g].fin;
    end
  end

  for (genvar g = 0; g < LEVELS; g++) begin : g_cell
    mhpq_cell #(
      .LEVEL       (g),
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .in_ctl     (cin_ctl[g]),
      .in_val     (cin_val[g]),
      .in_pos     (cin_pos[g]),
      .in_aux     (cin_aux[g]),
      .in_lvl     (cin_lvl[g]),
      .out_ctl    (cout_ctl[g]),
      .out_val    (cout_val[g]),
      .out_pos    (cout_pos[g]),
      .out_aux    (cout_aux[g]),
      .out_lvl    (cout_lvl[g]),
      .wb_in_en   (wbin_en[g]),
      .wb_in_pos  (wbin_pos[g]),
      .wb_in_val  (wbin_val[g]),
      .wb_out_en  (wbout_en[g]),
      .wb_out_pos (wbout_pos[g]),
      .wb_out_val (wbout_val[g]),
      .fetch_en   (fetch_en[g]),
      .fetch_pos  (pop_pos),
      .rd_val     (rd_val[g]),
      .stat       (stat[g]),
      .wr_val     (wr_val[g])
    );
  end

  // output register: load the result, hold it until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      top_out_q   <= empty ? '0 : top_field;
      count_out_q <= count_field;
      empty_out_q <= empty;
      rej_out_q   <= rej_q;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, count_out_q, top_out_q};
  assign m_tuser = {rej_out_q, empty_out_q};

endmodule

// File: sim/mhpq_result_checker.sv
module mhpq_result_checker #(
  parameter int unsigned CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  input  logic                               s_tready,
  // s_tdata: value [31:0]
  input  logic [mhpq_pkg::VALUE_FIELD_W-1:0] s_tdata,
  // s_tuser: action [0]
  input  logic                               s_tuser,
  input  logic                               m_tvalid,
  input  logic                               m_tready,
  // m_tdata: top_value [31:0], entry_count [42:32], zero fill [47:43]
  input  logic [mhpq_pkg::OUT_TDATA_W-1:0]   m_tdata,
  // m_tuser: is_empty [0], rejected [1]
  input  logic [mhpq_pkg::OUT_TUSER_W-1:0]   m_tuser,
  output int unsigned                        fail_count,
  output int unsigned                        pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mhpq_pkg::*;

  typedef struct packed {
    logic [VALUE_FIELD_W-1:0] top_value;
    logic [COUNT_FIELD_W-1:0] entry_count;
    logic                     is_empty;
    logic                     rejected;
  } queue_status_t;

  logic signed [VALUE_FIELD_W-1:0] heap_mem [CAPACITY];
  int unsigned                     heap_len = 0;
  queue_status_t                   status_q [$];
  int unsigned                     errs = 0;

  function automatic void swap_nodes(input int unsigned a, input int unsigned b);
    logic signed [VALUE_FIELD_W-1:0] t;
    t           = heap_mem[a];
    heap_mem[a] = heap_mem[b];
    heap_mem[b] = t;
  endfunction

  // Apply one push or pop to the heap copy and return the queue status after it
  function automatic queue_status_t heap_step(input op_t op,
                                              input logic signed [VALUE_FIELD_W-1:0] val);
    queue_status_t st;
    int unsigned   pos;
    int unsigned   up;
    int unsigned   best;
    int unsigned   lc;
    int unsigned   rc;
    st.rejected = 1'b0;
    if (op == OP_PUSH) begin
      if (heap_len >= CAPACITY) begin
        st.rejected = 1'b1;
      end else begin
        heap_mem[heap_len] = val;
        pos = heap_len;
        heap_len++;
        // sift up while strictly greater than the parent
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (heap_mem[pos] > heap_mem[up]) begin
            swap_nodes(pos, up);
            pos = up;
          end else begin
            break;
          end
        end
      end
    end else if (heap_len == 0) begin
      st.rejected = 1'b1;
    end else begin
      heap_len--;
      heap_mem[0] = heap_mem[heap_len];
      pos = 0;
      // sift down toward the larger child, left child wins a tie
      while (pos < heap_len) begin
        best = pos;
        lc   = 2 * pos + 1;
        rc   = 2 * pos + 2;
        if (lc < heap_len && heap_mem[best] < heap_mem[lc]) best = lc;
        if (rc < heap_len && heap_mem[best] < heap_mem[rc]) best = rc;
        if (best == pos) break;
        swap_nodes(pos, best);
        pos = best;
      end
    end
    st.entry_count = heap_len[COUNT_FIELD_W-1:0];
    st.is_empty    = (heap_len == 0);
    st.top_value   = (heap_len == 0) ? '0 : heap_mem[0];
    return st;
  endfunction

  always @(posedge clk) begin : watch
    queue_status_t want;
    if (rst) begin
      heap_len = 0;
      status_q.delete();
    end else begin
      // Results first: a same-edge input can never be the source of this one
      if (m_tvalid && m_tready) begin
        if (status_q.size() == 0) begin
          $error("result transfer with no item outstanding");
          errs++;
        end else begin
          want = status_q.pop_front();
          if (m_tdata[31:0] !== want.top_value) begin
            $error("top_value: expected %0d, actual %0d",
                   $signed(want.top_value), $signed(m_tdata[31:0]));
            errs++;
          end
          if (m_tdata[42:32] !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d",
                   want.entry_count, m_tdata[42:32]);
            errs++;
          end
          if (m_tuser[0] !== want.is_empty) begin
            $error("is_empty: expected %0b, actual %0b", want.is_empty, m_tuser[0]);
            errs++;
          end
          if (m_tuser[1] !== want.rejected) begin
            $error("rejected: expected %0b, actual %0b", want.rejected, m_tuser[1]);
            errs++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        status_q = {status_q, heap_step(op_t'(s_tuser), s_tdata)};
      end
    end
    pending    <= status_q.size();
    fail_count <= errs;
  end

endmodule

// File: sim/tb_max_heap_priority_queue_core.sv
module tb_max_heap_priority_queue_core;
  timeunit 1ns;
  timeprecision 1ps;
  import mhpq_pkg::*;

  localparam int unsigned QCAP         = CAPACITY_DEF;
  localparam int unsigned CLK_HALF     = 5;
  localparam int unsigned RESET_CYCLES = 7;
  // Longest correct quiet stretch is the long receiver hold-off plus one
  // sift; take it many times over.
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned DRAIN_TAIL   = 60;

  logic                     clk      = 1'b0;
  logic                     rst      = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  // s_tdata: value [31:0]
  logic [VALUE_FIELD_W-1:0] s_tdata  = '0;
  // s_tuser: action [0] (0 push, 1 pop)
  logic                     s_tuser  = OP_PUSH;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  // m_tdata: top_value [31:0], entry_count [42:32], zero fill [47:43]
  logic [OUT_TDATA_W-1:0]   m_tdata;
  // m_tuser: is_empty [0], rejected [1]
  logic [OUT_TUSER_W-1:0]   m_tuser;

  int unsigned fail_count;
  int unsigned pending;

  // Stimulus shaping
  int unsigned send_idle_pct = 15;
  int unsigned sink_idle_pct = 84;
  bit          hold_req      = 1'b0;
  bit          hold_done     = 1'b0;
  int unsigned quiet_cycles  = 0;

  // Running fill level of the queue, used only to steer the stimulus
  int unsigned fill_level    = 0;
  int unsigned push_rejects  = 0;

  always #(CLK_HALF) clk = ~clk;

  max_heap_priority_queue_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  mhpq_result_checker #(.CAPACITY(QCAP)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Pick a value: mostly full-range random, some extremes, some small values
  // so that equal keys meet inside the heap.
  function automatic logic [VALUE_FIELD_W-1:0] pick_value();
    case ($urandom_range(11))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3, 4:    return 32'($urandom_range(15)) - 32'd8;
      default: return $urandom();
    endcase
  endfunction

  // Offer one item and hold it until the transfer. Idle first at the
  // sender's rate; tvalid is only driven once per edge.
  task automatic send_item(input op_t op, input logic [VALUE_FIELD_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= val;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op == OP_PUSH) begin
      if (fill_level < QCAP) fill_level++;
      else push_rejects++;
    end else if (fill_level > 0) begin
      fill_level--;
    end
  endtask

  task automatic send_random(input int unsigned push_pct);
    op_t op;
    op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
    send_item(op, pick_value());
  endtask

  // Drop tvalid and wait until every expected result has come back. Step one
  // edge first so the count includes the last transfer.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Receiver: random tready at the current idle rate, plus one long
  // hold-off when requested so the block backs up and stalls its input.
  initial begin : sink
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Watchdog: end the run when nothing transfers for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("max_heap_priority_queue_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: pop of an empty queue, extremes, a duplicated maximum,
    // alternating bit patterns, a full drain and pops past empty.
    send_item(OP_POP, $urandom());
    send_item(OP_PUSH, 32'h0000_0000);
    send_item(OP_PUSH, 32'h7FFF_FFFF);
    send_item(OP_PUSH, 32'h8000_0000);
    send_item(OP_PUSH, 32'hFFFF_FFFF);
    send_item(OP_PUSH, 32'h7FFF_FFFF);
    send_item(OP_PUSH, 32'h0000_0001);
    send_item(OP_PUSH, 32'hAAAA_AAAA);
    send_item(OP_PUSH, 32'h5555_5555);
    repeat (8) send_item(OP_POP, $urandom());
    send_item(OP_POP, $urandom());
    send_item(OP_PUSH, 32'h8000_0000);
    send_item(OP_PUSH, 32'h8000_0000);
    repeat (3) send_item(OP_POP, $urandom());

    // Balanced random walk near empty: frequent pops of an empty queue
    repeat (300) send_random(55);

    // Pause the sender until the block has answered everything
    wait_drained();

    // Swap the idle rates and fill to capacity, then push into a full store
    send_idle_pct  = 84;
    sink_idle_pct <= 15;
    while (push_rejects < 12) send_random(97);

    // No idling; open with the long receiver hold-off while the sender keeps
    // offering, then drain mostly with pops.
    send_idle_pct  = 0;
    sink_idle_pct <= 0;
    hold_req      <= 1'b1;
    repeat (520) send_random(12);

    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);

    if (fail_count == 0) begin
      $display("max_heap_priority_queue_core test passed");
    end else begin
      $display("max_heap_priority_queue_core test failed");
    end
    $finish;
  end

endmodule
